// ===== sv/md5sh_pkg.sv =====
// md5sh_pkg: shared types, constants and round tables for the md5 stream hasher
// used by md5sh_core and md5_stream_hasher; no dependencies
package md5sh_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_CPRE,
		ST_COMP,
		ST_CADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       load;
		logic       round;
		logic       finish;
		logic       reinit;
		logic [5:0] rnd;
	} core_ctrl_t;

	function automatic logic [3:0] md5_g(input logic [5:0] i);
		logic [3:0] x;
		logic [3:0] g;
		x = i[3:0];
		case (i[5:4])
			2'd0: g = x;
			2'd1: g = 4'((x << 2) + x + 4'd1);
			2'd2: g = 4'((x << 1) + x + 4'd5);
			2'd3: g = 4'((x << 3) - x);
			default: g = x;
		endcase
		return g;
	endfunction

	function automatic logic [4:0] md5_s(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			4'd15: s = 5'd21;
			default: s = 5'd7;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = 32'hd76aa478;
		endcase
		return k;
	endfunction

endpackage

// ===== sv/md5sh_block_ram.sv =====
// md5sh_block_ram: 16 x 32 message block memory, one write and one read port
// registered read data; no dependencies
module md5sh_block_ram (
	input  logic        clk,
	input  logic        we,
	input  logic [3:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [3:0]  raddr,
	output logic [31:0] rdata
);

	logic [31:0] mem [16];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/md5sh_core.sv =====
// md5sh_core: chaining words and one md5 round per cycle while ctrl.round is set, on working registers
// depends on md5sh_pkg
module md5sh_core (
	input  logic                clk,
	input  logic                arst_n,
	input  md5sh_pkg::core_ctrl_t ctrl,
	input  logic [31:0]         msg_word,
	input  logic [1:0]          out_idx,
	output logic [31:0]         digest
);

	import md5sh_pkg::*;

	logic [31:0] chain_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [31:0] f;
	logic [31:0] sum;
	logic [63:0] rot_full;

	always_comb begin
		case (ctrl.rnd[5:4])
			2'd0: f = d_q ^ (b_q & (c_q ^ d_q));
			2'd1: f = c_q ^ (d_q & (b_q ^ c_q));
			2'd2: f = b_q ^ c_q ^ d_q;
			2'd3: f = c_q ^ (b_q | ~d_q);
			default: f = b_q ^ c_q ^ d_q;
		endcase
		sum = a_q + f + msg_word + md5_k(ctrl.rnd);
		rot_full = {sum, sum} << md5_s(ctrl.rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q[0] <= IV_A;
			chain_q[1] <= IV_B;
			chain_q[2] <= IV_C;
			chain_q[3] <= IV_D;
		end else if (ctrl.reinit) begin
			chain_q[0] <= IV_A;
			chain_q[1] <= IV_B;
			chain_q[2] <= IV_C;
			chain_q[3] <= IV_D;
		end else if (ctrl.finish) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
		end else if (ctrl.round) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + rot_full[63:32];
		end
	end

	assign digest = chain_q[out_idx];

endmodule

// ===== sv/md5_stream_hasher.sv =====
// md5_stream_hasher: top level, byte packing, padding and sequencing of the md5 hasher
// depends on md5sh_pkg, md5sh_block_ram and md5sh_core
//
// One message byte is taken per item and packed little-endian into a 16-word block
// memory. While a block is compressed the input is stalled: a read setup state, the 64
// rounds (one round per cycle, fed by the block memory read port) and a state to fold
// into the chaining words. Ending a message writes the padding one word per cycle (up
// to the 16 words of a block, a second pass when the length needs an extra block), runs
// the final compression(s), then presents the four digest words, word_index 0 first,
// final_word set on the last. After the last word is taken the hasher reloads its
// initial values and accepts the next message.
module md5_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        final_word
);

	import md5sh_pkg::*;

	state_t      state_q, state_d;
	logic [60:0] count_q;
	logic [31:0] cur_word_q;
	logic        eom_q;
	logic        final_q;
	logic        len_blk_q;
	logic        pad_first_q;
	logic [3:0]  pad_ptr_q;
	logic [5:0]  rnd_q;
	logic [1:0]  out_idx_q;

	logic        in_acc;
	logic        out_acc;
	logic [31:0] byte_word;
	logic [31:0] first_word;
	logic [3:0]  pad_ptr;
	logic        pad_len;
	logic [63:0] bit_len;
	logic        we;
	logic [3:0]  waddr;
	logic [31:0] wdata;
	logic [3:0]  raddr;
	logic [31:0] rdata;
	core_ctrl_t  ctrl;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign bit_len = {count_q, 3'b000};
	assign pad_ptr = pad_first_q ? count_q[5:2] : pad_ptr_q;
	assign pad_len = pad_first_q ? (count_q[5:3] != 3'b111) : len_blk_q;

	always_comb begin
		byte_word = cur_word_q;
		byte_word[count_q[1:0]*8 +: 8] = data_byte;
		for (int k = 0; k < 4; k++) begin
			if (k < int'(count_q[1:0])) begin
				first_word[k*8 +: 8] = cur_word_q[k*8 +: 8];
			end else if (k == int'(count_q[1:0])) begin
				first_word[k*8 +: 8] = PAD_BYTE;
			end else begin
				first_word[k*8 +: 8] = 8'h00;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = count_q[5:2];
		wdata = byte_word;
		raddr = md5_g(6'(rnd_q + 6'd1));
		ctrl = '0;
		ctrl.rnd = rnd_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && byte_present) begin
					we = (count_q[1:0] == 2'd3);
					if (count_q[5:0] == 6'd63) begin
						state_d = ST_CPRE;
					end else if (end_of_message) begin
						state_d = ST_PAD;
					end
				end else if (in_acc && end_of_message) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				we = 1'b1;
				waddr = pad_ptr;
				if (pad_first_q) begin
					wdata = first_word;
				end else if (pad_len && pad_ptr == 4'd14) begin
					wdata = bit_len[31:0];
				end else if (pad_len && pad_ptr == 4'd15) begin
					wdata = bit_len[63:32];
				end else begin
					wdata = '0;
				end
				if (pad_ptr == 4'd15) begin
					state_d = ST_CPRE;
				end
			end
			ST_CPRE: begin
				raddr = md5_g(6'd0);
				ctrl.load = 1'b1;
				state_d = ST_COMP;
			end
			ST_COMP: begin
				ctrl.round = 1'b1;
				if (rnd_q == 6'd63) begin
					state_d = ST_CADD;
				end
			end
			ST_CADD: begin
				ctrl.finish = 1'b1;
				if (final_q) begin
					state_d = ST_EMIT;
				end else if (eom_q) begin
					state_d = ST_PAD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_acc && out_idx_q == 2'd3) begin
					ctrl.reinit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			eom_q <= 1'b0;
			final_q <= 1'b0;
			len_blk_q <= 1'b0;
			pad_first_q <= 1'b0;
			pad_ptr_q <= '0;
			rnd_q <= '0;
			out_idx_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (byte_present) begin
							count_q <= count_q + 61'd1;
						end
						eom_q <= end_of_message;
						pad_first_q <= 1'b1;
						final_q <= 1'b0;
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					// the block after a pass without the length carries it
					len_blk_q <= pad_len || (pad_ptr == 4'd15);
					pad_ptr_q <= pad_ptr + 4'd1;
					final_q <= pad_len;
				end
				ST_CPRE: begin
					rnd_q <= '0;
				end
				ST_COMP: begin
					rnd_q <= rnd_q + 6'd1;
				end
				ST_CADD: begin
					out_idx_q <= '0;
				end
				ST_EMIT: begin
					if (out_acc) begin
						out_idx_q <= out_idx_q + 2'd1;
						if (out_idx_q == 2'd3) begin
							count_q <= '0;
							eom_q <= 1'b0;
							final_q <= 1'b0;
						end
					end
				end
				default: begin
					rnd_q <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && byte_present) begin
			cur_word_q <= byte_word;
		end
	end

	md5sh_block_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	md5sh_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.msg_word (rdata),
		.out_idx  (out_idx_q),
		.digest   (digest_word)
	);

	assign word_index = out_idx_q;
	assign final_word = (out_idx_q == 2'd3);

endmodule

// ===== tb/md5_digest_checker.sv =====
// md5_digest_checker: watches both channels of md5_stream_hasher, predicts the md5 digest
// of every message from the accepted bytes and compares each digest word in order
// standalone, no package needed; instantiated by md5_stream_hasher_test
module md5_digest_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] digest_word,
	input  logic [1:0]  word_index,
	input  logic        final_word,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  index;
		logic        last;
	} digest_word_t;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  MARK_BYTE = 8'h80;

	localparam logic [31:0] ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ROUND_ROT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	logic [31:0]  chain [4];
	logic [31:0]  blk [16];
	logic [60:0]  nbytes;
	digest_word_t digest_q [$];

	function automatic void load_iv();
		chain[0] = INIT_A;
		chain[1] = INIT_B;
		chain[2] = INIT_C;
		chain[3] = INIT_D;
		nbytes = '0;
	endfunction

	function automatic void put_byte(input int pos, input logic [7:0] v);
		blk[pos / 4][(pos % 4) * 8 +: 8] = v;
	endfunction

	function automatic void compress_block();
		logic [31:0] a, b, c, d, f, t;
		int g, s;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin
					f = d ^ (b & (c ^ d));
					g = i;
				end
				1: begin
					f = c ^ (d & (b ^ c));
					g = 5 * i + 1;
				end
				2: begin
					f = b ^ c ^ d;
					g = 3 * i + 5;
				end
				default: begin
					f = c ^ (b | ~d);
					g = 7 * i;
				end
			endcase
			s = ROUND_ROT[(i / 16) * 4 + i % 4];
			t = a + f + blk[g % 16] + ROUND_K[i];
			t = (t << s) | (t >> (32 - s));
			a = d;
			d = c;
			c = b;
			b = b + t;
		end
		chain[0] = chain[0] + a;
		chain[1] = chain[1] + b;
		chain[2] = chain[2] + c;
		chain[3] = chain[3] + d;
	endfunction

	function automatic void absorb_item(input logic [7:0] b, input logic p, input logic e);
		int pos;
		logic [63:0] bits;
		if (p) begin
			put_byte(int'(nbytes[5:0]), b);
			nbytes = nbytes + 61'd1;
			if (nbytes[5:0] == 6'd0)
				compress_block();
		end
		if (e) begin
			pos = int'(nbytes[5:0]);
			put_byte(pos, MARK_BYTE);
			for (int k = pos + 1; k < 64; k++)
				put_byte(k, 8'h00);
			// no room for the length: extra block
			if (pos >= 56) begin
				compress_block();
				for (int k = 0; k < 16; k++)
					blk[k] = '0;
			end
			bits = {nbytes, 3'b000};
			blk[14] = bits[31:0];
			blk[15] = bits[63:32];
			compress_block();
			for (int k = 0; k < 4; k++)
				digest_q.push_back({chain[k], 2'(k), k == 3});
			load_iv();
		end
	endfunction

	function automatic void check_word();
		digest_word_t want;
		if (digest_q.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected digest word %h index %0d final %b",
					digest_word, word_index, final_word);
		end else begin
			want = digest_q.pop_front();
			if (digest_word !== want.word || word_index !== want.index ||
					final_word !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
						want.word, want.index, want.last,
						digest_word, word_index, final_word);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digest_q.delete();
			load_iv();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_word();
			if (in_valid && !in_stall)
				absorb_item(data_byte, byte_present, end_of_message);
			pending <= digest_q.size();
		end
	end

endmodule

// ===== tb/md5_stream_hasher_test.sv =====
// md5_stream_hasher_test: drives byte messages with random gaps and output stalls into
// md5_stream_hasher and gives the verdict; checking is done by md5_digest_checker
// depends on md5_stream_hasher and md5_digest_checker
module md5_stream_hasher_test;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        byte_present = 1'b0;
	logic        end_of_message = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        final_word;
	logic        steady = 1'b0;
	int          errors;
	int          pending;
	int          idle_cycles = 0;
	int          random_items = 0;
	int          messages = 0;
	int          len;

	md5_stream_hasher dut (.*);

	md5_digest_checker digest_check (.*);

	always #6 clk = ~clk;

	always @(posedge clk)
		out_stall <= !steady && $urandom_range(99) < 9;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("md5_stream_hasher test failed");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic p, input logic e);
		while (!steady && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_present <= p;
		end_of_message <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_digests();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic send_message(input int n);
		logic fold;
		fold = n > 0 && $urandom_range(1) == 1;
		for (int k = 0; k < n; k++) begin
			// empty item before a byte of the message
			if ($urandom_range(99) < 5)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, fold && k == n - 1);
			random_items++;
		end
		if (!fold) begin
			send_item(8'($urandom), 1'b0, 1'b1);
			random_items++;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, then an empty item before another empty message
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'h00, 1'b0, 1'b1);
		// "abc" with the end on the last byte
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		// single byte extremes
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		// end on an item of its own
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'haa, 1'b0, 1'b1);
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h7f, 1'b0, 1'b0);
		send_item(8'h01, 1'b0, 1'b1);
		wait_digests();

		while (random_items < 240 || messages < 12) begin
			steady <= messages >= 4 && messages < 7;
			if ($urandom_range(3) == 0)
				len = 55 + $urandom_range(10);
			else
				len = $urandom_range(15);
			send_message(len);
			messages++;
			if (messages == 3)
				wait_digests();
		end
		steady <= 1'b0;

		wait_digests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("md5_stream_hasher test passed");
		else
			$display("md5_stream_hasher test failed");
		$finish;
	end

endmodule
